>>> rtl/core/multichannel_frame_ring_fifo_top_defines.svh
`ifndef MULTICHANNEL_FRAME_RING_FIFO_TOP_DEFINES_SVH
`define MULTICHANNEL_FRAME_RING_FIFO_TOP_DEFINES_SVH

// same-cycle check, sampled on clk, off while arst_n is low
`define MFRF_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// check in the cycle after the antecedent
`define MFRF_ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) else $error(msg);

`endif

>>> rtl/core/mfrf_pkg.sv
`default_nettype none

package mfrf_pkg;

	localparam int DEPTH_FRAMES = 1024;
	localparam int ADDR_W       = $clog2(DEPTH_FRAMES);
	localparam int MAX_CHANNELS = 8;
	localparam int SAMPLE_W     = 32;
	localparam int FILL_W       = 10;
	localparam int CH_W         = 4;
	localparam int CFG_IDX_W    = 2;
	localparam logic [CH_W-1:0] CH_RESET = CH_W'(2);

	typedef enum logic [1:0] {
		OP_PUSH  = 2'd0,
		OP_POP   = 2'd1,
		OP_CLEAR = 2'd2,
		OP_NOP   = 2'd3
	} mfrf_op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_RING_CHANNELS = CFG_IDX_W'(0),
		REG_OUT_CHANNELS  = CFG_IDX_W'(1)
	} mfrf_reg_t;

	typedef struct packed {
		logic              issue;
		logic              wr_en;
		logic              rd_en;
		logic [ADDR_W-1:0] addr;
	} mfrf_cmd_t;

	typedef struct packed {
		logic              ok;
		logic [FILL_W-1:0] fill;
	} mfrf_res_t;

	typedef logic [MAX_CHANNELS-1:0][SAMPLE_W-1:0] mfrf_frame_t;

	function automatic logic [CH_W-1:0] clamp_ch(input logic [CH_W-1:0] v);
		return (v > CH_W'(MAX_CHANNELS)) ? CH_W'(MAX_CHANNELS) : v;
	endfunction

endpackage

`default_nettype wire

>>> rtl/core/mfrf_lane.sv
`default_nettype none

module mfrf_lane (
	input  logic                          clk,
	input  mfrf_pkg::mfrf_cmd_t           cmd,
	input  logic                          keep,
	input  logic [mfrf_pkg::SAMPLE_W-1:0] wdata,
	output logic [mfrf_pkg::SAMPLE_W-1:0] rdata
);
	import mfrf_pkg::*;

	logic [SAMPLE_W-1:0] mem [DEPTH_FRAMES];
	logic [SAMPLE_W-1:0] rd_s1;
	logic                keep_s1;

	always_ff @(posedge clk) begin
		if (cmd.wr_en) begin
			mem[cmd.addr] <= wdata;
		end
		if (cmd.rd_en) begin
			rd_s1 <= mem[cmd.addr];
		end
		if (cmd.issue) begin
			keep_s1 <= keep;
		end
	end

	// channels outside the active count and non-pop results read as silence
	assign rdata = keep_s1 ? rd_s1 : '0;

endmodule

`default_nettype wire

>>> rtl/core/mfrf_ctrl.sv
`default_nettype none
`include "multichannel_frame_ring_fifo_top_defines.svh"

module mfrf_ctrl (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                fire,
	input  logic [1:0]                          opcode,
	input  logic                                cfg_we,
	input  logic [mfrf_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [mfrf_pkg::CH_W-1:0]           cfg_data,
	output mfrf_pkg::mfrf_cmd_t                 cmd,
	output logic [mfrf_pkg::MAX_CHANNELS-1:0]   keep,
	output mfrf_pkg::mfrf_res_t                 res
);
	import mfrf_pkg::*;

	logic [ADDR_W-1:0] wr_idx_q, rd_idx_q;
	logic [ADDR_W-1:0] wr_nxt, rd_nxt;
	logic [ADDR_W-1:0] held, fill_nxt;
	logic [CH_W-1:0]   ring_ch_q, out_ch_q;
	logic [CH_W-1:0]   rc, oc, n_ch;
	logic              full, empty, ok, pop_ok;
	mfrf_op_t          op;

	assign op    = mfrf_op_t'(opcode);
	assign held  = wr_idx_q - rd_idx_q;
	assign full  = (held == ADDR_W'(DEPTH_FRAMES - 1));
	assign empty = (held == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ring_ch_q <= CH_RESET;
			out_ch_q  <= CH_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_RING_CHANNELS: ring_ch_q <= cfg_data;
				REG_OUT_CHANNELS:  out_ch_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		wr_nxt = wr_idx_q;
		rd_nxt = rd_idx_q;
		ok     = 1'b0;
		pop_ok = 1'b0;
		unique case (op)
			OP_PUSH: begin
				if (!full) begin
					wr_nxt = wr_idx_q + ADDR_W'(1);
					ok     = 1'b1;
				end
			end
			OP_POP: begin
				if (!empty) begin
					rd_nxt = rd_idx_q + ADDR_W'(1);
					ok     = 1'b1;
					pop_ok = 1'b1;
				end
			end
			OP_CLEAR: begin
				wr_nxt = '0;
				rd_nxt = '0;
				ok     = 1'b1;
			end
			OP_NOP: ;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_idx_q <= '0;
			rd_idx_q <= '0;
		end else if (fire) begin
			wr_idx_q <= wr_nxt;
			rd_idx_q <= rd_nxt;
		end
	end

	assign rc   = clamp_ch(ring_ch_q);
	assign oc   = clamp_ch(out_ch_q);
	assign n_ch = (rc < oc) ? rc : oc;

	always_comb begin
		for (int c = 0; c < MAX_CHANNELS; c++) begin
			keep[c] = pop_ok && (CH_W'(c) < n_ch);
		end
	end

	assign fill_nxt  = wr_nxt - rd_nxt;
	assign cmd.issue = fire;
	assign cmd.wr_en = fire && (op == OP_PUSH) && !full;
	assign cmd.rd_en = fire && pop_ok;
	assign cmd.addr  = (op == OP_PUSH) ? wr_idx_q : rd_idx_q;
	assign res.ok    = ok;
	assign res.fill  = FILL_W'(fill_nxt);

	`MFRF_ASSERT_NEXT(a_drop_keeps_wr, fire && op == OP_PUSH && full, $stable(wr_idx_q), "push into full ring moved write index")
	`MFRF_ASSERT_NEXT(a_underrun_keeps_rd, fire && op == OP_POP && empty, $stable(rd_idx_q), "pop from empty ring moved read index")
	`MFRF_ASSERT_NEXT(a_clear_zeroes, fire && op == OP_CLEAR, wr_idx_q == '0 && rd_idx_q == '0, "clear left nonzero indexes")

endmodule

`default_nettype wire

>>> rtl/core/mfrf_merge.sv
`default_nettype none
`include "multichannel_frame_ring_fifo_top_defines.svh"

module mfrf_merge (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              fire,
	input  mfrf_pkg::mfrf_res_t               res,
	input  mfrf_pkg::mfrf_frame_t             lane_data,
	input  logic                              out_ready,
	output logic                              s1_ready,
	output logic                              out_valid,
	output logic                              ok,
	output logic [mfrf_pkg::FILL_W-1:0]       fill_level,
	output mfrf_pkg::mfrf_frame_t             samples
);
	import mfrf_pkg::*;

	logic              valid_s1;
	logic              ok_s1;
	logic [FILL_W-1:0] fill_s1;
	logic              out_valid_q;
	logic              ok_q;
	logic [FILL_W-1:0] fill_q;
	mfrf_frame_t       samples_q;
	logic              advance;

	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign s1_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (fire) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			ok_s1   <= res.ok;
			fill_s1 <= res.fill;
		end
		if (advance) begin
			ok_q      <= ok_s1;
			fill_q    <= fill_s1;
			samples_q <= lane_data;
		end
	end

	assign out_valid  = out_valid_q;
	assign ok         = ok_q;
	assign fill_level = fill_q;
	assign samples    = samples_q;

	`MFRF_ASSERT(a_s1_not_overwritten, !(fire && valid_s1 && !advance), "stage one overwritten while stalled")
	`MFRF_ASSERT_NEXT(a_fire_fills_s1, fire, valid_s1, "accepted transaction missing in stage one")
	`MFRF_ASSERT(a_fail_is_silent, !(out_valid_q && !ok_q && samples_q != '0), "failed operation returned samples")

endmodule

`default_nettype wire

>>> rtl/core/multichannel_frame_ring_fifo_top.sv
// channel  direction  handshake              payload
// in       sink       in_valid / in_ready    opcode, in_sample_0..7
// out      source     out_valid / out_ready  ok, fill_level, out_sample_0..7
// cfg      sink       cfg_valid / cfg_ready  cfg_index, cfg_data (always ready)
//
// one transaction per cycle sustained while out_ready is high; its result passes through stage one
// (the registered read port of the per-channel lane memories) and then the output register
// arst_n clears the frame indexes and sets both channel counts to two; store is not cleared
// a stalled output holds its result while one more transaction waits in stage one
`default_nettype none

module multichannel_frame_ring_fifo_top (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [1:0]                          opcode,
	input  logic [mfrf_pkg::SAMPLE_W-1:0]       in_sample_0,
	input  logic [mfrf_pkg::SAMPLE_W-1:0]       in_sample_1,
	input  logic [mfrf_pkg::SAMPLE_W-1:0]       in_sample_2,
	input  logic [mfrf_pkg::SAMPLE_W-1:0]       in_sample_3,
	input  logic [mfrf_pkg::SAMPLE_W-1:0]       in_sample_4,
	input  logic [mfrf_pkg::SAMPLE_W-1:0]       in_sample_5,
	input  logic [mfrf_pkg::SAMPLE_W-1:0]       in_sample_6,
	input  logic [mfrf_pkg::SAMPLE_W-1:0]       in_sample_7,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic                                ok,
	output logic [mfrf_pkg::FILL_W-1:0]         fill_level,
	output logic [mfrf_pkg::SAMPLE_W-1:0]       out_sample_0,
	output logic [mfrf_pkg::SAMPLE_W-1:0]       out_sample_1,
	output logic [mfrf_pkg::SAMPLE_W-1:0]       out_sample_2,
	output logic [mfrf_pkg::SAMPLE_W-1:0]       out_sample_3,
	output logic [mfrf_pkg::SAMPLE_W-1:0]       out_sample_4,
	output logic [mfrf_pkg::SAMPLE_W-1:0]       out_sample_5,
	output logic [mfrf_pkg::SAMPLE_W-1:0]       out_sample_6,
	output logic [mfrf_pkg::SAMPLE_W-1:0]       out_sample_7,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [mfrf_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [mfrf_pkg::CH_W-1:0]           cfg_data
);
	import mfrf_pkg::*;

	logic                    fire;
	logic                    s1_ready;
	mfrf_cmd_t               cmd;
	mfrf_res_t               res;
	logic [MAX_CHANNELS-1:0] keep;
	mfrf_frame_t             wdata;
	mfrf_frame_t             lane_data;
	mfrf_frame_t             samples;

	assign cfg_ready = 1'b1;
	assign in_ready  = s1_ready;
	assign fire      = in_valid && in_ready;

	assign wdata = {in_sample_7, in_sample_6, in_sample_5, in_sample_4,
	                in_sample_3, in_sample_2, in_sample_1, in_sample_0};

	mfrf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (fire),
		.opcode    (opcode),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.keep      (keep),
		.res       (res)
	);

	for (genvar g = 0; g < MAX_CHANNELS; g++) begin : g_lane
		mfrf_lane u_lane (
			.clk   (clk),
			.cmd   (cmd),
			.keep  (keep[g]),
			.wdata (wdata[g]),
			.rdata (lane_data[g])
		);
	end

	mfrf_merge u_merge (
		.clk        (clk),
		.arst_n     (arst_n),
		.fire       (fire),
		.res        (res),
		.lane_data  (lane_data),
		.out_ready  (out_ready),
		.s1_ready   (s1_ready),
		.out_valid  (out_valid),
		.ok         (ok),
		.fill_level (fill_level),
		.samples    (samples)
	);

	assign out_sample_0 = samples[0];
	assign out_sample_1 = samples[1];
	assign out_sample_2 = samples[2];
	assign out_sample_3 = samples[3];
	assign out_sample_4 = samples[4];
	assign out_sample_5 = samples[5];
	assign out_sample_6 = samples[6];
	assign out_sample_7 = samples[7];

endmodule

`default_nettype wire
